@@ hdl/tbeh_pkg.sv @@
// Shared types, constants and codes for the time-binned event histogram.
`timescale 1ns / 1ps
`default_nettype none

package tbeh_pkg;

	// Sizing
	localparam int BIN_STORE_DEPTH = 64;
	localparam int BAR_FULL_HEIGHT = 50;
	localparam int STORE_AW        = $clog2(BIN_STORE_DEPTH);
	localparam int BAR_Q_W         = $clog2(BAR_FULL_HEIGHT + 1);
	localparam int CNT_W           = 32;
	localparam int PROD_W          = CNT_W + BAR_Q_W;
	localparam int BIN_W           = 6;
	localparam int BAR_W           = 6;
	localparam int WEIGHT_W        = 24;
	localparam int HOURS_W         = 15;
	localparam int UNITS_W         = 7;
	localparam int STEP_W          = 6;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 7;
	localparam int CMD_Q_DEPTH     = 2;
	localparam int CMD_Q_AW        = $clog2(CMD_Q_DEPTH);
	localparam int CMD_Q_CW        = $clog2(CMD_Q_DEPTH + 1);

	// Time constants
	localparam logic [CNT_W-1:0]   SEC_PER_HOUR = 32'd3600;
	localparam logic [CNT_W-1:0]   WEEK_OFFSET  = 32'd259200;
	localparam logic [BIN_W-1:0]   MAX_BINS     = 6'd49;
	localparam logic [BIN_W-1:0]   BINS_HOURS   = 6'd24;
	localparam logic [BIN_W-1:0]   BINS_DAYS    = 6'd7;
	localparam logic [HOURS_W-1:0] HOURS_ONE    = 15'd1;
	localparam logic [HOURS_W-1:0] HOURS_DAY    = 15'd24;

	// Operation codes
	localparam logic [1:0] OP_RECORD  = 2'd0;
	localparam logic [1:0] OP_READOUT = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	// Register field codes
	localparam logic [1:0] SRC_CHARS   = 2'd0;
	localparam logic [1:0] SRC_MSGS    = 2'd1;
	localparam logic [1:0] SRC_CHATS   = 2'd2;
	localparam logic [1:0] DIR_IN      = 2'd0;
	localparam logic [1:0] DIR_OUT     = 2'd1;
	localparam logic [1:0] DIR_BOTH    = 2'd2;
	localparam logic [1:0] MODE_HOURS  = 2'd0;
	localparam logic [1:0] MODE_DAYS   = 2'd1;
	localparam logic [1:0] UNIT_DAY    = 2'd1;
	localparam logic [1:0] UNIT_WEEK   = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_SOURCE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_MODE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_UNIT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNITS_PER_BIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_WEEK_ALIGN    = 3'd6;

	typedef struct packed {
		logic [1:0]          operation;
		logic                is_chat;
		logic                is_outgoing;
		logic [CNT_W-1:0]    event_time;
		logic [WEIGHT_W-1:0] message_length;
	} item_t;

	typedef struct packed {
		logic [BIN_W-1:0] bin_index;
		logic [CNT_W-1:0] bin_count;
		logic [BAR_W-1:0] bar_height;
		logic             last;
	} result_t;

	typedef enum logic [1:0] {
		CMD_RECORD,
		CMD_READ,
		CMD_CLEAR
	} cmd_op_t;

	// Classified command passed from the front end to the back end
	typedef struct packed {
		cmd_op_t             op;
		logic [WEIGHT_W-1:0] weight;
		logic [CNT_W-1:0]    stamp;
		logic [HOURS_W-1:0]  hours;
		logic [BIN_W-1:0]    nbins;
	} cmd_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] init_rem;
		logic [CNT_W-1:0] dividend;
		logic [STEP_W-1:0] steps;
		logic [CNT_W-1:0] divisor;
		logic [BIN_W-1:0] modulus;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] quot;
		logic [CNT_W-1:0] rem;
		logic [BIN_W-1:0] modv;
	} div_rsp_t;

endpackage

`default_nettype wire

@@ hdl/time_binned_event_histogram.sv @@
// Top level of the time-binned event histogram.
`timescale 1ns / 1ps
`default_nettype none

// Counts timestamped message and chat events into a periodic histogram of
// up to 49 time bins and reads the histogram out on request. Each input
// transaction is a record, readout or clear operation; filtering, weight
// selection and bin geometry are settled in the front end from the current
// configuration, and the classified command waits in a two-entry queue for
// the back end, so the input side keeps taking transactions while the back
// end is busy, until the queue is full. A record pops the queue, takes its
// bin index from a shared shift-subtract divider that builds the 32-bit
// quotient (the mod-bins value is built alongside it), then reads and
// writes the bin store. A readout first scans the bins in use for the
// peak, then for each bin runs the bar division on the same divider and
// waits while the result register still holds a report that has not been
// popped. A clear flags every bin empty at once; each bin reads as zero
// until written again. Counts saturate at 2^32-1. Configuration is picked
// up by the next input transaction; write it only while the block is idle.

module time_binned_event_histogram
	import tbeh_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input queue side
	input  wire logic                  push,
	input  wire item_t                 item,
	output logic                       full,
	// result queue side
	output result_t                    result,
	output logic                       empty,
	input  wire logic                  pop
);

	logic q_wr;
	logic q_rd;
	logic q_full;
	logic q_empty;
	cmd_t q_wr_cmd;
	cmd_t q_rd_cmd;

	// Accept and classify; drop filtered events and unknown operations here
	tbeh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.item      (item),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_cmd     (q_wr_cmd)
	);

	// Decouple the two halves so each can stall on its own
	tbeh_fifo u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_cmd),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (q_rd_cmd),
		.empty   (q_empty)
	);

	// Carry out the commands against the bin store
	tbeh_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_cmd   (q_rd_cmd),
		.q_rd    (q_rd),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

	// Hold off the input side only when the command queue is full
	assign full = q_full;

endmodule

`default_nettype wire

@@ hdl/tbeh_front.sv @@
// Front end: configuration registers, event filtering and bin setup.
`timescale 1ns / 1ps
`default_nettype none

module tbeh_front
	import tbeh_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  push,
	input  wire item_t                 item,
	input  wire logic                  q_full,
	output logic                       q_wr,
	output cmd_t                       q_cmd
);

	logic [1:0]         data_source_q;
	logic [1:0]         direction_q;
	logic [1:0]         split_mode_q;
	logic [1:0]         bin_unit_q;
	logic [UNITS_W-1:0] units_q;
	logic [BIN_W-1:0]   bins_q;
	logic               week_align_q;

	logic               dir_ok;
	logic [WEIGHT_W-1:0] weight;
	logic [HOURS_W-1:0] hours;
	logic [HOURS_W-1:0] units_ext;
	logic [BIN_W-1:0]   nbins;
	logic [CNT_W-1:0]   offset;
	logic               keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_source_q <= SRC_CHARS;
			direction_q   <= DIR_BOTH;
			split_mode_q  <= MODE_HOURS;
			bin_unit_q    <= 2'd0;
			units_q       <= 7'd6;
			bins_q        <= 6'd28;
			week_align_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DATA_SOURCE:   data_source_q <= cfg_data[1:0];
				CFG_DIRECTION:     direction_q   <= cfg_data[1:0];
				CFG_SPLIT_MODE:    split_mode_q  <= cfg_data[1:0];
				CFG_BIN_UNIT:      bin_unit_q    <= cfg_data[1:0];
				CFG_UNITS_PER_BIN: units_q       <= cfg_data[UNITS_W-1:0];
				CFG_BINS_IN_USE:   bins_q        <= cfg_data[BIN_W-1:0];
				CFG_WEEK_ALIGN:    week_align_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Filter and weight
	always_comb begin
		case (direction_q)
			DIR_BOTH: dir_ok = 1'b1;
			DIR_IN:   dir_ok = !item.is_outgoing;
			DIR_OUT:  dir_ok = item.is_outgoing;
			default:  dir_ok = 1'b0;
		endcase

		weight = '0;
		if (item.is_chat) begin
			if (data_source_q == SRC_CHATS) weight = WEIGHT_W'(1);
		end else begin
			if (data_source_q == SRC_CHARS) weight = item.message_length;
			else if (data_source_q == SRC_MSGS) weight = WEIGHT_W'(1);
		end
	end

	// Bin geometry; hours per bin uses shifts for the 24 and 168 factors
	always_comb begin
		units_ext = HOURS_W'(units_q == '0 ? UNITS_W'(1) : units_q);
		case (split_mode_q)
			MODE_HOURS: begin
				hours  = HOURS_ONE;
				nbins  = BINS_HOURS;
				offset = '0;
			end
			MODE_DAYS: begin
				hours  = HOURS_DAY;
				nbins  = BINS_DAYS;
				offset = WEEK_OFFSET;
			end
			default: begin
				case (bin_unit_q)
					UNIT_DAY:  hours = (units_ext << 4) + (units_ext << 3);
					UNIT_WEEK: hours = (units_ext << 7) + (units_ext << 5) + (units_ext << 3);
					default:   hours = units_ext;
				endcase
				if (bins_q == '0)          nbins = BIN_W'(1);
				else if (bins_q > MAX_BINS) nbins = MAX_BINS;
				else                        nbins = bins_q;
				offset = week_align_q ? WEEK_OFFSET : '0;
			end
		endcase
	end

	always_comb begin
		q_cmd.weight = weight;
		q_cmd.stamp  = item.event_time + offset;
		q_cmd.hours  = hours;
		q_cmd.nbins  = nbins;
		case (item.operation)
			OP_RECORD: begin
				q_cmd.op = CMD_RECORD;
				keep     = dir_ok && (weight != '0);
			end
			OP_READOUT: begin
				q_cmd.op = CMD_READ;
				keep     = 1'b1;
			end
			OP_CLEAR: begin
				q_cmd.op = CMD_CLEAR;
				keep     = 1'b1;
			end
			default: begin
				q_cmd.op = CMD_RECORD;
				keep     = 1'b0;
			end
		endcase
	end

	assign q_wr = push && !q_full && keep;

endmodule

`default_nettype wire

@@ hdl/tbeh_fifo.sv @@
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module tbeh_fifo
	import tbeh_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire cmd_t wr_data,
	output logic      full,
	input  wire logic rd,
	output cmd_t      rd_data,
	output logic      empty
);

	cmd_t                entry_q [CMD_Q_DEPTH];
	logic [CMD_Q_AW-1:0] wr_ptr_q;
	logic [CMD_Q_AW-1:0] rd_ptr_q;
	logic [CMD_Q_CW-1:0] count_q;

	assign full    = (count_q == CMD_Q_CW'(CMD_Q_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + CMD_Q_AW'(1);
			if (rd) rd_ptr_q <= rd_ptr_q + CMD_Q_AW'(1);
			if (wr && !rd)      count_q <= count_q + CMD_Q_CW'(1);
			else if (rd && !wr) count_q <= count_q - CMD_Q_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) entry_q[wr_ptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

@@ hdl/tbeh_div.sv @@
// Shared shift-subtract divider, one quotient bit per cycle, with a running mod-n of the quotient.
`timescale 1ns / 1ps
`default_nettype none

module tbeh_div
	import tbeh_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  sh_q;
	logic [CNT_W-1:0]  quot_q;
	logic [CNT_W-1:0]  dvsr_q;
	logic [BIN_W-1:0]  mod_q;
	logic [BIN_W-1:0]  modn_q;

	logic [CNT_W:0]    trial;
	logic              ge;
	logic [CNT_W-1:0]  rem_nx;
	logic [BIN_W:0]    mtrial;
	logic [BIN_W-1:0]  mod_nx;

	always_comb begin
		trial  = {rem_q, sh_q[CNT_W-1]};
		ge     = (trial >= {1'b0, dvsr_q});
		rem_nx = ge ? CNT_W'(trial - {1'b0, dvsr_q}) : CNT_W'(trial);
		// quotient bit folded into the remainder modulo n, MSB first
		mtrial = {mod_q, ge};
		mod_nx = (mtrial >= {1'b0, modn_q}) ? BIN_W'(mtrial - {1'b0, modn_q})
		                                    : BIN_W'(mtrial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			sh_q   <= '0;
			quot_q <= '0;
			dvsr_q <= '0;
			mod_q  <= '0;
			modn_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
				rem_q  <= req.init_rem;
				sh_q   <= req.dividend;
				quot_q <= '0;
				dvsr_q <= req.divisor;
				mod_q  <= '0;
				modn_q <= req.modulus;
			end else if (busy_q) begin
				rem_q  <= rem_nx;
				sh_q   <= sh_q << 1;
				quot_q <= {quot_q[CNT_W-2:0], ge};
				mod_q  <= mod_nx;
				cnt_q  <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;
	assign rsp.modv = mod_q;

endmodule

`default_nettype wire

@@ hdl/tbeh_back.sv @@
// Back end: bin store, record/readout/clear sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

module tbeh_back
	import tbeh_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  wire cmd_t q_cmd,
	output logic      q_rd,
	output result_t   result,
	output logic      empty,
	input  wire logic pop
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EV_DIV,
		ST_EV_RD,
		ST_EV_WR,
		ST_SC_RD,
		ST_SC_CMP,
		ST_BR_RD,
		ST_BR_MUL,
		ST_BR_START,
		ST_BR_DIV,
		ST_BR_OUT
	} state_t;

	state_t                    state_q;
	logic [BIN_W-1:0]          idx_q;
	logic [BIN_W-1:0]          nbins_q;
	logic [WEIGHT_W-1:0]       weight_q;
	logic [CNT_W-1:0]          peak_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [PROD_W-1:0]         prod_q;
	logic [BAR_Q_W-1:0]        bar_q;
	result_t                   out_q;
	logic                      out_valid_q;
	logic [BIN_STORE_DEPTH-1:0] vld_q;

	logic [CNT_W-1:0]          mem_q [BIN_STORE_DEPTH];
	logic [CNT_W-1:0]          rd_data_q;
	logic                      rd_vld_q;

	logic [STORE_AW-1:0]       addr;
	logic                      mem_re;
	logic                      mem_we;
	logic [CNT_W:0]            sum;
	logic [CNT_W-1:0]          wr_data;
	logic [CNT_W-1:0]          cur_cnt;
	logic [CNT_W-1:0]          peak_eff;
	logic [BAR_Q_W-1:0]        bar_full;
	logic                      is_last;
	logic                      out_load;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	tbeh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign addr     = STORE_AW'(idx_q);
	assign mem_re   = (state_q == ST_EV_RD) || (state_q == ST_SC_RD) || (state_q == ST_BR_RD);
	assign mem_we   = (state_q == ST_EV_WR);
	assign cur_cnt  = rd_vld_q ? rd_data_q : '0;
	assign sum      = {1'b0, cur_cnt} + (CNT_W + 1)'(weight_q);
	assign wr_data  = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
	assign peak_eff = (peak_q == '0) ? CNT_W'(1) : peak_q;
	assign bar_full = div_rsp.quot[BAR_Q_W-1:0] + BAR_Q_W'(div_rsp.rem != '0);
	assign is_last  = (idx_q == nbins_q - BIN_W'(1));
	assign out_load = (state_q == ST_BR_OUT) && (!out_valid_q || pop);
	assign q_rd     = (state_q == ST_IDLE) && !q_empty;

	always_comb begin
		div_req          = '0;
		div_req.modulus  = nbins_q;
		if (q_rd && q_cmd.op == CMD_RECORD) begin
			div_req.start    = 1'b1;
			div_req.init_rem = '0;
			div_req.dividend = q_cmd.stamp;
			div_req.steps    = STEP_W'(CNT_W);
			div_req.divisor  = CNT_W'(q_cmd.hours) * SEC_PER_HOUR;
			div_req.modulus  = q_cmd.nbins;
		end else if (state_q == ST_BR_START) begin
			// quotient fits in BAR_Q_W bits, so the upper part is already a remainder
			div_req.start    = 1'b1;
			div_req.init_rem = prod_q[PROD_W-1:BAR_Q_W];
			div_req.dividend = {prod_q[BAR_Q_W-1:0], {(CNT_W - BAR_Q_W){1'b0}}};
			div_req.steps    = STEP_W'(BAR_Q_W);
			div_req.divisor  = peak_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			nbins_q     <= BIN_W'(1);
			weight_q    <= '0;
			peak_q      <= '0;
			cnt_q       <= '0;
			prod_q      <= '0;
			bar_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
		end else begin
			if (pop && out_valid_q) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_rd) begin
						nbins_q  <= q_cmd.nbins;
						weight_q <= q_cmd.weight;
						idx_q    <= '0;
						peak_q   <= '0;
						case (q_cmd.op)
							CMD_RECORD: state_q <= ST_EV_DIV;
							CMD_READ:   state_q <= ST_SC_RD;
							CMD_CLEAR:  vld_q   <= '0;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_EV_DIV: begin
					if (div_rsp.done) begin
						idx_q   <= div_rsp.modv;
						state_q <= ST_EV_RD;
					end
				end
				ST_EV_RD: state_q <= ST_EV_WR;
				ST_EV_WR: begin
					vld_q[addr] <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_SC_RD: state_q <= ST_SC_CMP;
				ST_SC_CMP: begin
					if (cur_cnt > peak_q) peak_q <= cur_cnt;
					if (is_last) begin
						idx_q   <= '0;
						state_q <= ST_BR_RD;
					end else begin
						idx_q   <= idx_q + BIN_W'(1);
						state_q <= ST_SC_RD;
					end
				end
				ST_BR_RD: state_q <= ST_BR_MUL;
				ST_BR_MUL: begin
					cnt_q   <= cur_cnt;
					prod_q  <= PROD_W'(BAR_FULL_HEIGHT) * PROD_W'(cur_cnt);
					state_q <= ST_BR_START;
				end
				ST_BR_START: state_q <= ST_BR_DIV;
				ST_BR_DIV: begin
					if (div_rsp.done) begin
						bar_q   <= bar_full;
						state_q <= ST_BR_OUT;
					end
				end
				ST_BR_OUT: begin
					if (out_load) begin
						out_q.bin_index  <= idx_q;
						out_q.bin_count  <= cnt_q;
						out_q.bar_height <= BAR_W'(bar_q);
						out_q.last       <= is_last;
						out_valid_q      <= 1'b1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + BIN_W'(1);
							state_q <= ST_BR_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[addr] <= wr_data;
		if (mem_re) begin
			rd_data_q <= mem_q[addr];
			rd_vld_q  <= vld_q[addr];
		end
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

	a_bin_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> idx_q < nbins_q)
		else $error("record writes a bin beyond the bins in use");

	a_count_below_peak: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BR_MUL |-> cur_cnt <= peak_q)
		else $error("reported count exceeds the scanned peak");

	a_bar_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BR_DIV && div_rsp.done) |-> bar_full <= BAR_Q_W'(BAR_FULL_HEIGHT))
		else $error("bar height above full scale");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_EV_DIV || state_q == ST_BR_DIV))
		else $error("divider finished with no waiting sequencer");

endmodule

`default_nettype wire

@@ bench/time_binned_event_histogram_tb.sv @@
// Self-checking testbench for the time-binned event histogram: directed table, then paced random traffic.
`timescale 1ns / 1ps

module time_binned_event_histogram_tb;
	import tbeh_pkg::*;

	// Bin geometry as the histogram defines it
	localparam int unsigned HOUR_SECONDS = 3600;
	localparam int unsigned DAY_SECONDS  = 86400;
	localparam int unsigned WEEK_SHIFT   = 3 * DAY_SECONDS;
	localparam int unsigned BIN_LIMIT    = 49;

	// Run shaping
	localparam int SETTLE_CYCLES  = 200;   // covers two queued records plus one in flight
	localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transaction
	localparam int CHUNK_ITEMS    = 14;    // transactions per register setting
	localparam int FLOOD_RECORDS  = 280;   // enough near-full lengths to pass 2^32-1

	// Codes the package leaves unnamed
	localparam logic [1:0] OP_UNKNOWN   = 2'd3;
	localparam logic [1:0] SRC_UNKNOWN  = 2'd3;
	localparam logic [1:0] DIR_UNKNOWN  = 2'd3;
	localparam logic [1:0] MODE_CUSTOM  = 2'd2;
	localparam logic [1:0] MODE_UNKNOWN = 2'd3;
	localparam logic [1:0] UNIT_HOUR    = 2'd0;
	localparam logic [1:0] UNIT_UNKNOWN = 2'd3;

	typedef enum logic [1:0] {
		ROW_CONFIG,
		ROW_EVENT,
		ROW_TYPED
	} row_kind_t;

	// One line of the directed table. A typed row carries its readout by hand:
	// every bin zero except hot_bin, which holds hot_count (and so a full bar).
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_value;
		item_t                 txn;
		logic [BIN_W-1:0]      hot_bin;
		logic [CNT_W-1:0]      hot_count;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  push;
	item_t                 item;
	logic                  full;
	result_t               result;
	logic                  empty;
	logic                  pop;

	// Shadow of the histogram: bin store and register file
	logic [CNT_W-1:0] bin_tally [BIN_STORE_DEPTH];
	logic [1:0]       cfg_source;
	logic [1:0]       cfg_direction;
	logic [1:0]       cfg_mode;
	logic [1:0]       cfg_unit;
	logic [6:0]       cfg_units;
	logic [5:0]       cfg_bins;
	logic             cfg_week;

	result_t   pending_bins [$];   // bin reports still owed by the block
	stim_row_t directed_rows [$];
	result_t   awaited;

	int error_count     = 0;
	int items_sent      = 0;
	int reports_checked = 0;
	int settings_used   = 0;
	int send_idle_pct   = 17;
	int recv_idle_pct   = 84;
	bit block_dirty     = 1'b0;  // set once a transaction may still be in flight
	int stall_cycles    = 0;

	time_binned_event_histogram DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.item      (item),
		.full      (full),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow histogram
	// ------------------------------------------------------------------

	// Work out divisor, bin count and time shift for the current mode.
	// Unknown modes fall into the custom branch, unknown units count as hours.
	function automatic void bin_geometry(output logic [31:0] period, output logic [5:0] span,
			output logic [31:0] shift);
		int unsigned hours;
		int unsigned units;
		int unsigned nb;
		if (cfg_mode == MODE_HOURS) begin
			period = HOUR_SECONDS;
			span   = 24;
			shift  = 0;
		end else if (cfg_mode == MODE_DAYS) begin
			period = DAY_SECONDS;
			span   = 7;
			shift  = WEEK_SHIFT;
		end else begin
			hours = (cfg_unit == UNIT_DAY) ? 24 : (cfg_unit == UNIT_WEEK) ? 168 : 1;
			units = (cfg_units == 0) ? 1 : cfg_units;
			nb    = (cfg_bins == 0) ? 1 : cfg_bins;
			if (nb > BIN_LIMIT)
				nb = BIN_LIMIT;
			period = HOUR_SECONDS * hours * units;
			span   = nb;
			shift  = cfg_week ? WEEK_SHIFT : 0;
		end
	endfunction

	// Filter, weigh and add one event to its bin, saturating at all ones.
	function automatic void tally_event(item_t ev);
		logic [31:0] period;
		logic [31:0] shift;
		logic [31:0] stamp;
		logic [31:0] slot;
		logic [5:0]  span;
		logic [31:0] weight;
		logic [32:0] sum;
		logic        passes;
		passes = (cfg_direction == DIR_BOTH) ||
			(cfg_direction == DIR_IN && !ev.is_outgoing) ||
			(cfg_direction == DIR_OUT && ev.is_outgoing);
		if (ev.is_chat)
			weight = (cfg_source == SRC_CHATS) ? 32'd1 : 32'd0;
		else if (cfg_source == SRC_CHARS)
			weight = ev.message_length;
		else if (cfg_source == SRC_MSGS)
			weight = 32'd1;
		else
			weight = 32'd0;
		if (!passes || weight == 0)
			return;
		bin_geometry(period, span, shift);
		stamp = ev.event_time + shift;  // wraps at 32 bits on purpose
		slot  = (stamp / period) % span;
		sum   = {1'b0, bin_tally[slot]} + weight;
		bin_tally[slot] = sum[32] ? '1 : sum[31:0];
	endfunction

	// Queue one report per bin in use, bars scaled to the peak.
	function automatic void report_bins();
		logic [31:0]     period;
		logic [31:0]     shift;
		logic [5:0]      span;
		longint unsigned peak;
		longint unsigned cnt;
		longint unsigned bar;
		result_t         rep;
		int              j;
		bin_geometry(period, span, shift);
		peak = 0;
		for (j = 0; j < span; j++)
			if (bin_tally[j] > peak)
				peak = bin_tally[j];
		if (peak == 0)
			peak = 1;
		for (j = 0; j < span; j++) begin
			cnt = bin_tally[j];
			bar = (BAR_FULL_HEIGHT * cnt + peak - 1) / peak;
			rep.bin_index  = j;
			rep.bin_count  = bin_tally[j];
			rep.bar_height = bar[BAR_W-1:0];
			rep.last       = (j == span - 1);
			pending_bins.push_back(rep);
		end
	endfunction

	// Hand-typed readout: one hot bin, all others empty.
	function automatic void expect_typed_readout(logic [BIN_W-1:0] hot_bin,
			logic [CNT_W-1:0] hot_count);
		logic [31:0] period;
		logic [31:0] shift;
		logic [5:0]  span;
		result_t     rep;
		int          j;
		bin_geometry(period, span, shift);
		for (j = 0; j < span; j++) begin
			rep.bin_index  = j;
			rep.bin_count  = (j == hot_bin) ? hot_count : '0;
			rep.bar_height = (rep.bin_count != 0) ? BAR_FULL_HEIGHT : 0;
			rep.last       = (j == span - 1);
			pending_bins.push_back(rep);
		end
	endfunction

	function automatic void absorb(item_t ev);
		case (ev.operation)
			OP_RECORD:  tally_event(ev);
			OP_READOUT: report_bins();
			OP_CLEAR:   foreach (bin_tally[k]) bin_tally[k] = '0;
			default:    ;  // unknown operation leaves everything alone
		endcase
	endfunction

	function automatic void shadow_register(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_DATA_SOURCE:   cfg_source    = val[1:0];
			CFG_DIRECTION:     cfg_direction = val[1:0];
			CFG_SPLIT_MODE:    cfg_mode      = val[1:0];
			CFG_BIN_UNIT:      cfg_unit      = val[1:0];
			CFG_UNITS_PER_BIN: cfg_units     = val[6:0];
			CFG_BINS_IN_USE:   cfg_bins      = val[5:0];
			CFG_WEEK_ALIGN:    cfg_week      = val[0];
			default:           ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Present one transaction and hold it until taken. Push is left high on
	// return so back-to-back transactions need no extra edge.
	task automatic send_event(item_t ev, bit typed, logic [BIN_W-1:0] hot_bin,
			logic [CNT_W-1:0] hot_count);
		bit taken;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= ev;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !full;
			if (!taken)
				@(negedge clk);
		end
		items_sent++;
		block_dirty = 1'b1;
		if (typed)
			expect_typed_readout(hot_bin, hot_count);
		else
			absorb(ev);
	endtask

	// Drop push, wait for every owed report, then let queued records finish.
	task automatic settle_block();
		@(negedge clk);
		push <= 1'b0;
		while (pending_bins.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		block_dirty = 1'b0;
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		if (block_dirty)
			settle_block();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		shadow_register(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Fresh random setting of every register. Extremes and unknown codes turn
	// up often; unused upper data bits carry junk the block must mask off.
	task automatic pick_setting();
		logic [6:0] junk;
		logic [1:0] code;
		logic [6:0] units_val;
		logic [5:0] bins_val;
		junk = $urandom;
		code = ($urandom_range(9) == 0) ? SRC_UNKNOWN : 2'($urandom_range(2));
		write_register(CFG_DATA_SOURCE, {junk[6:2], code});
		junk = $urandom;
		code = ($urandom_range(9) == 0) ? DIR_UNKNOWN : 2'($urandom_range(2));
		write_register(CFG_DIRECTION, {junk[6:2], code});
		junk = $urandom;
		write_register(CFG_SPLIT_MODE, {junk[6:2], 2'($urandom_range(3))});
		junk = $urandom;
		write_register(CFG_BIN_UNIT, {junk[6:2], 2'($urandom_range(3))});
		case ($urandom_range(5))
			0:       units_val = 7'd0;
			1:       units_val = 7'd1;
			2:       units_val = 7'd100;
			3:       units_val = 7'd127;
			default: units_val = 7'($urandom_range(100, 1));
		endcase
		write_register(CFG_UNITS_PER_BIN, units_val);
		case ($urandom_range(5))
			0:       bins_val = 6'd0;
			1:       bins_val = 6'd1;
			2:       bins_val = 6'd49;
			3:       bins_val = 6'd63;
			default: bins_val = 6'($urandom_range(49, 1));
		endcase
		junk = $urandom;
		write_register(CFG_BINS_IN_USE, {junk[6], bins_val});
		junk = $urandom;
		write_register(CFG_WEEK_ALIGN, {junk[6:1], 1'($urandom_range(1))});
		settings_used++;
	endtask

	// Mostly events that get through the current filter; the rest are random.
	function automatic item_t random_event();
		item_t       ev;
		int unsigned pick;
		pick = $urandom_range(99);
		ev.operation = (pick < 72) ? OP_RECORD : (pick < 85) ? OP_READOUT :
			(pick < 91) ? OP_CLEAR : OP_UNKNOWN;
		ev.is_chat     = $urandom_range(1);
		ev.is_outgoing = $urandom_range(1);
		if ($urandom_range(3) != 0) begin
			ev.is_chat = (cfg_source == SRC_CHATS);
			if (cfg_direction == DIR_IN)
				ev.is_outgoing = 1'b0;
			else if (cfg_direction == DIR_OUT)
				ev.is_outgoing = 1'b1;
		end
		case ($urandom_range(3))
			0:       ev.event_time = $urandom_range(700000);
			1:       ev.event_time = 32'hFFFF_FFFF - $urandom_range(700000);
			default: ev.event_time = $urandom;
		endcase
		case ($urandom_range(5))
			0:       ev.message_length = '0;
			1:       ev.message_length = $urandom_range(255);
			2:       ev.message_length = 24'hFF_FFFF - $urandom_range(15);
			default: ev.message_length = $urandom;
		endcase
		return ev;
	endfunction

	// Random traffic in chunks, each under a new setting and closed by a
	// readout so the store is seen before the setting moves on.
	task automatic random_run(int quota);
		int    counted;
		item_t ev;
		counted = 0;
		while (counted < quota) begin
			pick_setting();
			repeat (CHUNK_ITEMS) begin
				ev = random_event();
				send_event(ev, 1'b0, '0, '0);
				if (ev.operation != OP_UNKNOWN)
					counted++;
			end
			ev = random_event();
			ev.operation = OP_READOUT;
			send_event(ev, 1'b0, '0, '0);
			counted++;
		end
	endtask

	// Pile near-full message lengths into a single bin until it saturates.
	task automatic saturate_one_bin();
		item_t ev;
		int    n;
		write_register(CFG_DATA_SOURCE, SRC_CHARS);
		write_register(CFG_DIRECTION, DIR_BOTH);
		write_register(CFG_SPLIT_MODE, MODE_CUSTOM);
		write_register(CFG_BIN_UNIT, 7'($urandom_range(3)));
		write_register(CFG_UNITS_PER_BIN, 7'($urandom_range(127)));
		write_register(CFG_BINS_IN_USE, 7'd1);
		write_register(CFG_WEEK_ALIGN, 7'($urandom_range(1)));
		settings_used++;
		ev = random_event();
		ev.operation = OP_CLEAR;
		send_event(ev, 1'b0, '0, '0);
		for (n = 0; n < FLOOD_RECORDS; n++) begin
			ev = random_event();
			ev.operation      = OP_RECORD;
			ev.is_chat        = 1'b0;
			ev.message_length = 24'hFF_FFFF - $urandom_range(63);
			send_event(ev, 1'b0, '0, '0);
			if (n % 70 == 69) begin
				ev.operation = OP_READOUT;
				send_event(ev, 1'b0, '0, '0);
			end
		end
	endtask

	function automatic void add_row(row_kind_t kind, logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val, logic [1:0] op, logic chat, logic outgoing,
			logic [31:0] stamp, logic [23:0] len, logic [BIN_W-1:0] hot_bin,
			logic [CNT_W-1:0] hot_count);
		stim_row_t row;
		row.kind                = kind;
		row.reg_index           = idx;
		row.reg_value           = val;
		row.txn.operation       = op;
		row.txn.is_chat         = chat;
		row.txn.is_outgoing     = outgoing;
		row.txn.event_time      = stamp;
		row.txn.message_length  = len;
		row.hot_bin             = hot_bin;
		row.hot_count           = hot_count;
		directed_rows.push_back(row);
	endfunction

	// ------------------------------------------------------------------
	// Result side: random pop pacing and the checker
	// ------------------------------------------------------------------

	always @(negedge clk)
		pop <= ($urandom_range(99) >= recv_idle_pct);

	function automatic void compare_field(string field, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_bins.size() == 0) begin
				error_count++;
				$display("%0t ns: bin report with none owed, expected nothing, got bin %0d count %0d",
					$time, result.bin_index, result.bin_count);
			end else begin
				awaited = pending_bins.pop_front();
				reports_checked++;
				compare_field("bin_index", awaited.bin_index, result.bin_index);
				compare_field("bin_count", awaited.bin_count, result.bin_count);
				compare_field("bar_height", awaited.bar_height, result.bar_height);
				compare_field("last", awaited.last, result.last);
			end
		end
	end

	// Watchdog: any transaction on either side restarts the count
	initial begin
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("time_binned_event_histogram_tb: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		stim_row_t row;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_DATA_SOURCE;
		cfg_data  = '0;
		push      = 1'b0;
		item      = '0;
		pop       = 1'b0;

		// Shadow state as it comes out of reset
		foreach (bin_tally[k]) bin_tally[k] = '0;
		cfg_source    = SRC_CHARS;
		cfg_direction = DIR_BOTH;
		cfg_mode      = MODE_HOURS;
		cfg_unit      = UNIT_HOUR;
		cfg_units     = 7'd6;
		cfg_bins      = 6'd28;
		cfg_week      = 1'b1;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table. Columns: kind, register, value, operation, chat,
		// outgoing, time, length, hot bin, hot count.
		// Straight out of reset every hour bin reads empty
		add_row(ROW_TYPED, '0, '0, OP_READOUT, 0, 0, 32'd0, 24'd0, 6'd0, 32'd0);
		// Zero length adds nothing
		add_row(ROW_EVENT, '0, '0, OP_RECORD, 0, 0, 32'd0, 24'd0, '0, '0);
		// Latest time, longest message: hour 6 of the day
		add_row(ROW_EVENT, '0, '0, OP_RECORD, 0, 1, 32'hFFFF_FFFF, 24'hFF_FFFF, '0, '0);
		// Chat start weighs nothing while characters are counted
		add_row(ROW_EVENT, '0, '0, OP_RECORD, 1, 0, 32'd1234, 24'hFF_FFFF, '0, '0);
		// Unknown operation with every field at its top
		add_row(ROW_EVENT, '0, '0, OP_UNKNOWN, 1, 1, 32'hFFFF_FFFF, 24'hFF_FFFF, '0, '0);
		add_row(ROW_TYPED, '0, '0, OP_READOUT, 0, 0, 32'd0, 24'd0, 6'd6, 32'h00FF_FFFF);
		// Switch to days of week: counts survive the mode change
		add_row(ROW_CONFIG, CFG_SPLIT_MODE, MODE_DAYS, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_READOUT, 0, 0, 32'd0, 24'd0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_CLEAR, 0, 0, 32'd0, 24'd0, '0, '0);
		add_row(ROW_TYPED, '0, '0, OP_READOUT, 0, 0, 32'd0, 24'd0, 6'd0, 32'd0);
		// Unknown source records nothing
		add_row(ROW_CONFIG, CFG_DATA_SOURCE, SRC_UNKNOWN, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_RECORD, 0, 1, 32'd12345, 24'd100, '0, '0);
		// Unknown direction filter records nothing either
		add_row(ROW_CONFIG, CFG_DATA_SOURCE, SRC_MSGS, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_CONFIG, CFG_DIRECTION, DIR_UNKNOWN, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_RECORD, 0, 0, 32'd3600, 24'd7, '0, '0);
		// Incoming only: outgoing dropped, empty message still counts once
		add_row(ROW_CONFIG, CFG_DIRECTION, DIR_IN, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_RECORD, 0, 1, 32'd345600, 24'd9, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_RECORD, 0, 0, 32'd345600, 24'd0, '0, '0);
		// Chats, outgoing only: messages weigh nothing
		add_row(ROW_CONFIG, CFG_DATA_SOURCE, SRC_CHATS, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_CONFIG, CFG_DIRECTION, DIR_OUT, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_RECORD, 1, 1, 32'd86399, 24'd0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_RECORD, 0, 1, 32'd86399, 24'd50, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_READOUT, 0, 0, 32'd0, 24'd0, '0, '0);
		// Unknown mode and unit, zero units and zero bins: one hourly bin
		add_row(ROW_CONFIG, CFG_SPLIT_MODE, MODE_UNKNOWN, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_CONFIG, CFG_BIN_UNIT, UNIT_UNKNOWN, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_CONFIG, CFG_UNITS_PER_BIN, 7'd0, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_CONFIG, CFG_BINS_IN_USE, 7'd0, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_CONFIG, CFG_WEEK_ALIGN, 7'd0, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_RECORD, 1, 1, 32'hFFFF_FFFF, 24'd0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_READOUT, 0, 0, 32'd0, 24'd0, '0, '0);
		// Custom weeks, widest bin and too many bins; offset wraps the latest time
		add_row(ROW_CONFIG, CFG_SPLIT_MODE, MODE_CUSTOM, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_CONFIG, CFG_BIN_UNIT, UNIT_WEEK, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_CONFIG, CFG_UNITS_PER_BIN, 7'd127, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_CONFIG, CFG_BINS_IN_USE, 7'd63, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_CONFIG, CFG_WEEK_ALIGN, 7'd1, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_RECORD, 1, 1, 32'hFFFF_FFFF, 24'd0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_RECORD, 1, 1, 32'd0, 24'd0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_READOUT, 0, 0, 32'd0, 24'd0, '0, '0);
		// Custom days, 100 units per bin, full 49 bins
		add_row(ROW_CONFIG, CFG_BIN_UNIT, UNIT_DAY, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_CONFIG, CFG_UNITS_PER_BIN, 7'd100, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_CONFIG, CFG_BINS_IN_USE, 7'd49, OP_RECORD, 0, 0, '0, '0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_RECORD, 1, 1, 32'h7FFF_FFFF, 24'd0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_READOUT, 0, 0, 32'd0, 24'd0, '0, '0);
		add_row(ROW_EVENT, '0, '0, OP_CLEAR, 0, 0, 32'd0, 24'd0, '0, '0);
		add_row(ROW_TYPED, '0, '0, OP_READOUT, 0, 0, 32'd0, 24'd0, 6'd0, 32'd0);

		// Eager sender, busy receiver for the table and the first random stretch
		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			case (row.kind)
				ROW_CONFIG: write_register(row.reg_index, row.reg_value);
				ROW_TYPED:  send_event(row.txn, 1'b1, row.hot_bin, row.hot_count);
				default:    send_event(row.txn, 1'b0, '0, '0);
			endcase
		end
		random_run(70);

		// Swap the pacing: sender mostly idle, receiver eager
		send_idle_pct = 84;
		recv_idle_pct = 17;
		random_run(70);

		// Full speed on both sides, including the saturation flood
		send_idle_pct = 0;
		recv_idle_pct = 0;
		saturate_one_bin();
		random_run(40);

		settle_block();
		$display("Covered directed corners, %0d register settings and a saturating flood;",
			settings_used);
		$display("%0d transactions sent, %0d bin reports compared.", items_sent, reports_checked);
		if (error_count == 0)
			$display("time_binned_event_histogram_tb: done, clean");
		else
			$display("time_binned_event_histogram_tb: done, errors");
		$finish;
	end

endmodule
